FILE: src/jqr_pkg.sv
// shared constants for the job queue with keyed removal
// used by job_queue_remove_by_id, its checker and the testbench
package jqr_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_BITS     = 16;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ID_IN_W  = 16;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned HEAD_W   = 17;
  localparam int unsigned JCOUNT_W = 5;

  localparam int unsigned ID_W    = (ID_BITS < ID_IN_W) ? ID_BITS : ID_IN_W;
  localparam int unsigned ENTRY_W = ID_W + TAG_W;
  localparam int unsigned ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_STATUS = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage

FILE: src/job_queue_remove_by_id.sv
// an append writes the ram in S_APP, then passes S_HEAD and S_FIN; a status read or a
// refused append passes S_HEAD and S_FIN only; a remove compares the entries in turn (S_SRD,
// S_SCMP), moves those behind the match forward (S_MRD, S_MWR), via the single ram read port
// throughput: one transaction at a time, in_stall_o is high until the result is registered
// reset: asynchronous, active low; the queue is empty, ram contents are left as they are
// depends on jqr_pkg and jqr_ram
module job_queue_remove_by_id (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [jqr_pkg::FUNC_W-1:0]    func_i,
  input  logic [jqr_pkg::ID_IN_W-1:0]   job_id_i,
  input  logic [jqr_pkg::TAG_W-1:0]     job_tag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [jqr_pkg::STATUS_W-1:0]  status_o,
  output logic signed [jqr_pkg::HEAD_W-1:0] head_id_o,
  output logic [jqr_pkg::TAG_W-1:0]     head_tag_o,
  output logic                          is_empty_o,
  output logic [jqr_pkg::JCOUNT_W-1:0]  job_count_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_APP  = 3'd1;
  localparam logic [2:0] S_SRD  = 3'd2;
  localparam logic [2:0] S_SCMP = 3'd3;
  localparam logic [2:0] S_MRD  = 3'd4;
  localparam logic [2:0] S_MWR  = 3'd5;
  localparam logic [2:0] S_HEAD = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  localparam int unsigned CW = jqr_pkg::CNT_W;
  localparam int unsigned AW = jqr_pkg::ADDR_W;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [jqr_pkg::STATUS_W-1:0] op_status_q, op_status_d;
  logic [jqr_pkg::ID_W-1:0]     id_q, id_d;
  logic [jqr_pkg::TAG_W-1:0]    tag_q, tag_d;

  logic                               out_valid_q, out_valid_d;
  logic [jqr_pkg::STATUS_W-1:0]       status_q, status_d;
  logic [jqr_pkg::HEAD_W-1:0]         head_id_q, head_id_d;
  logic [jqr_pkg::TAG_W-1:0]          head_tag_q, head_tag_d;
  logic                               empty_q, empty_d;
  logic [jqr_pkg::JCOUNT_W-1:0]       jcount_q, jcount_d;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [jqr_pkg::ENTRY_W-1:0]   ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [jqr_pkg::ENTRY_W-1:0]   ram_rdata;
  logic [jqr_pkg::ID_W-1:0]      rd_id;
  logic [jqr_pkg::TAG_W-1:0]     rd_tag;
  logic [CW-1:0]                 scan_inc;
  logic [CW-1:0]                 scan_inc2;
  logic                          in_acc;

  jqr_ram #(
    .WIDTH(jqr_pkg::ENTRY_W),
    .DEPTH(jqr_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_id     = ram_rdata[jqr_pkg::ENTRY_W-1 -: jqr_pkg::ID_W];
  assign rd_tag    = ram_rdata[jqr_pkg::TAG_W-1:0];
  assign scan_inc  = scan_q + CW'(1);
  assign scan_inc2 = scan_q + CW'(2);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    op_status_d = op_status_q;
    id_d        = id_q;
    tag_d       = tag_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    head_id_d   = head_id_q;
    head_tag_d  = head_tag_q;
    empty_d     = empty_q;
    jcount_d    = jcount_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[AW-1:0];
    ram_wdata   = {id_q, tag_q};
    ram_raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          id_d        = job_id_i[jqr_pkg::ID_W-1:0];
          tag_d       = job_tag_i;
          scan_d      = '0;
          op_status_d = jqr_pkg::ST_DONE;
          state_d     = S_HEAD;
          if (func_i == jqr_pkg::FN_APPEND) begin
            if (count_q == CW'(jqr_pkg::QUEUE_DEPTH)) begin
              op_status_d = jqr_pkg::ST_FULL;
            end else begin
              state_d = S_APP;
            end
          end else if (func_i == jqr_pkg::FN_REMOVE) begin
            if (count_q == '0) begin
              op_status_d = jqr_pkg::ST_NOT_FOUND;
            end else begin
              state_d = S_SRD;
            end
          end
        end
      end
      S_APP: begin
        ram_we    = 1'b1;
        ram_waddr = count_q[AW-1:0];
        count_d   = count_q + CW'(1);
        state_d   = S_HEAD;
      end
      S_SRD: begin
        ram_raddr = scan_q[AW-1:0];
        state_d   = S_SCMP;
      end
      S_SCMP: begin
        if (rd_id == id_q) begin
          if (scan_inc < count_q) begin
            state_d = S_MRD;
          end else begin
            count_d = count_q - CW'(1);
            state_d = S_HEAD;
          end
        end else begin
          scan_d = scan_inc;
          if (scan_inc == count_q) begin
            op_status_d = jqr_pkg::ST_NOT_FOUND;
            state_d     = S_HEAD;
          end else begin
            state_d = S_SRD;
          end
        end
      end
      S_MRD: begin
        ram_raddr = scan_inc[AW-1:0];
        state_d   = S_MWR;
      end
      S_MWR: begin
        ram_we    = 1'b1;
        ram_waddr = scan_q[AW-1:0];
        ram_wdata = ram_rdata;
        scan_d    = scan_inc;
        if (scan_inc2 < count_q) begin
          state_d = S_MRD;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = op_status_q;
          jcount_d    = jqr_pkg::JCOUNT_W'(count_q);
          if (count_q == '0) begin
            head_id_d  = '1;
            head_tag_d = '0;
            empty_d    = 1'b1;
          end else begin
            head_id_d  = jqr_pkg::HEAD_W'(rd_id);
            head_tag_d = rd_tag;
            empty_d    = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_status_q <= op_status_d;
    id_q        <= id_d;
    tag_q       <= tag_d;
    status_q    <= status_d;
    head_id_q   <= head_id_d;
    head_tag_q  <= head_tag_d;
    empty_q     <= empty_d;
    jcount_q    <= jcount_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign head_id_o   = head_id_q;
  assign head_tag_o  = head_tag_q;
  assign is_empty_o  = empty_q;
  assign job_count_o = jcount_q;

endmodule

FILE: src/jqr_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module jqr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/jqr_checker.sv
// port level checks for job_queue_remove_by_id, bound to the top level
// depends on jqr_pkg
module jqr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [jqr_pkg::STATUS_W-1:0]      status_o,
  input logic signed [jqr_pkg::HEAD_W-1:0] head_id_o,
  input logic [jqr_pkg::TAG_W-1:0]         head_tag_o,
  input logic                              is_empty_o,
  input logic [jqr_pkg::JCOUNT_W-1:0]      job_count_o
);

  // one transaction in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a transaction is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(head_id_o)
      && $stable(job_count_o))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> job_count_o <= jqr_pkg::JCOUNT_W'(jqr_pkg::QUEUE_DEPTH))
    else $error("job count beyond queue depth");

  a_empty_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (job_count_o == '0))
      && (!is_empty_o || (head_id_o == -17'sd1 && head_tag_o == '0)))
    else $error("empty flag, count and head disagree");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == jqr_pkg::ST_FULL
      |-> job_count_o == jqr_pkg::JCOUNT_W'(jqr_pkg::QUEUE_DEPTH))
    else $error("append refused while queue not full");

endmodule

bind job_queue_remove_by_id jqr_checker u_jqr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .status_o   (status_o),
  .head_id_o  (head_id_o),
  .head_tag_o (head_tag_o),
  .is_empty_o (is_empty_o),
  .job_count_o(job_count_o)
);

FILE: sim/tb.sv
// testbench for job_queue_remove_by_id: a directed table of jobs, then random
// transactions, each result checked in order against a bench job queue or against
// its table row; depends on jqr_pkg and the job_queue_remove_by_id rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [jqr_pkg::FUNC_W-1:0]        FN_SPARE      = 2'd3;
  localparam logic signed [jqr_pkg::HEAD_W-1:0] NO_HEAD       = '1;
  localparam int unsigned                       SCRIPT_ROWS   = 25;
  localparam int unsigned                       RANDOM_JOBS   = 1100;
  localparam int unsigned                       QUIET_LIMIT   = 4000;
  localparam int unsigned                       SETTLE_CYCLES = 4 * jqr_pkg::QUEUE_DEPTH + 8;
  localparam int unsigned                       MAX_REPORTS   = 10;

  typedef struct packed {
    logic [jqr_pkg::STATUS_W-1:0]      status;
    logic signed [jqr_pkg::HEAD_W-1:0] head_id;
    logic [jqr_pkg::TAG_W-1:0]         head_tag;
    logic                              is_empty;
    logic [jqr_pkg::JCOUNT_W-1:0]      count;
  } queue_view_t;

  typedef struct packed {
    logic [jqr_pkg::FUNC_W-1:0]  func;
    logic [jqr_pkg::ID_IN_W-1:0] id;
    logic [jqr_pkg::TAG_W-1:0]   tag;
    logic                        checked;
    queue_view_t                 view;
  } job_row_t;

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              in_valid_i  = 1'b0;
  logic [jqr_pkg::FUNC_W-1:0]        func_i      = '0;
  logic [jqr_pkg::ID_IN_W-1:0]       job_id_i    = '0;
  logic [jqr_pkg::TAG_W-1:0]         job_tag_i   = '0;
  logic                              out_stall_i = 1'b0;
  logic                              in_stall_o;
  logic                              out_valid_o;
  logic [jqr_pkg::STATUS_W-1:0]      status_o;
  logic signed [jqr_pkg::HEAD_W-1:0] head_id_o;
  logic [jqr_pkg::TAG_W-1:0]         head_tag_o;
  logic                              is_empty_o;
  logic [jqr_pkg::JCOUNT_W-1:0]      job_count_o;

  logic [jqr_pkg::ID_W-1:0]  held_id  [jqr_pkg::QUEUE_DEPTH];
  logic [jqr_pkg::TAG_W-1:0] held_tag [jqr_pkg::QUEUE_DEPTH];
  int unsigned      held_jobs  = 0;
  queue_view_t      views_due [$];
  job_row_t         live_row   = '0;
  job_row_t         job_script [SCRIPT_ROWS];
  int unsigned      faults     = 0;
  int unsigned      stall_left = 0;
  bit               idling     = 1'b1;

  job_queue_remove_by_id uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic job_row_t open_row(input logic [jqr_pkg::FUNC_W-1:0] func,
                                        input logic [jqr_pkg::ID_IN_W-1:0] id,
                                        input logic [jqr_pkg::TAG_W-1:0] tag);
    job_row_t row;
    row = '0;
    row.func = func;
    row.id = id;
    row.tag = tag;
    return row;
  endfunction

  function automatic job_row_t checked_row(input logic [jqr_pkg::FUNC_W-1:0] func,
                                           input logic [jqr_pkg::ID_IN_W-1:0] id,
                                           input logic [jqr_pkg::TAG_W-1:0] tag,
                                           input logic [jqr_pkg::STATUS_W-1:0] status,
                                           input logic signed [jqr_pkg::HEAD_W-1:0] head_id,
                                           input logic [jqr_pkg::TAG_W-1:0] head_tag,
                                           input logic is_empty,
                                           input logic [jqr_pkg::JCOUNT_W-1:0] count);
    job_row_t row;
    row = open_row(func, id, tag);
    row.checked = 1'b1;
    row.view = '{status, head_id, head_tag, is_empty, count};
    return row;
  endfunction

  function automatic string view_text(input queue_view_t v);
    return $sformatf("status=%0d head_id=%0d head_tag=%h empty=%b count=%0d",
                     v.status, v.head_id, v.head_tag, v.is_empty, v.count);
  endfunction

  task automatic apply_job(input logic [jqr_pkg::FUNC_W-1:0] func,
                           input logic [jqr_pkg::ID_IN_W-1:0] id,
                           input logic [jqr_pkg::TAG_W-1:0] tag, output queue_view_t view);
    logic [jqr_pkg::ID_W-1:0] key;
    int unsigned              hit;
    key = id[jqr_pkg::ID_W-1:0];
    view = '0;
    view.status = jqr_pkg::ST_DONE;
    if (func == jqr_pkg::FN_APPEND) begin
      if (held_jobs >= jqr_pkg::QUEUE_DEPTH) begin
        view.status = jqr_pkg::ST_FULL;
      end else begin
        held_id[held_jobs] = key;
        held_tag[held_jobs] = tag;
        held_jobs++;
      end
    end else if (func == jqr_pkg::FN_REMOVE) begin
      hit = held_jobs;
      for (int unsigned i = 0; i < held_jobs; i++) begin
        if (hit == held_jobs && held_id[i] == key) hit = i;
      end
      if (hit == held_jobs) begin
        view.status = jqr_pkg::ST_NOT_FOUND;
      end else begin
        for (int unsigned j = hit; j + 1 < held_jobs; j++) begin
          held_id[j] = held_id[j + 1];
          held_tag[j] = held_tag[j + 1];
        end
        held_jobs--;
      end
    end
    if (held_jobs == 0) begin
      view.head_id = NO_HEAD;
      view.head_tag = '0;
      view.is_empty = 1'b1;
    end else begin
      view.head_id = jqr_pkg::HEAD_W'(held_id[0]);
      view.head_tag = held_tag[0];
      view.is_empty = 1'b0;
    end
    view.count = jqr_pkg::JCOUNT_W'(held_jobs);
  endtask

  task automatic send_job(input job_row_t row);
    int unsigned gap;
    gap = idling ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      func_i <= jqr_pkg::FUNC_W'($urandom_range(0, 3));
      job_id_i <= jqr_pkg::ID_IN_W'($urandom);
      job_tag_i <= jqr_pkg::TAG_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= row.func;
    job_id_i <= row.id;
    job_tag_i <= row.tag;
    live_row = row;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    queue_view_t seen;
    queue_view_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen = '{status_o, head_id_o, head_tag_o, is_empty_o, job_count_o};
        if (views_due.size() == 0) begin
          faults++;
          if (faults <= MAX_REPORTS)
            $display("%0t: result with none outstanding: %s", $realtime, view_text(seen));
        end else begin
          want = views_due.pop_front();
          if (seen !== want) begin
            faults++;
            if (faults <= MAX_REPORTS) begin
              $display("%0t: expected %s", $realtime, view_text(want));
              $display("%0t:      got %s", $realtime, view_text(seen));
            end
          end
        end
      end
      if (out_valid_o) begin
        if (!out_stall_i) stall_left = idling ? $urandom_range(0, 4) : 0;
        else if (stall_left != 0) stall_left--;
      end
      if (in_valid_i && !in_stall_o) begin
        apply_job(func_i, job_id_i, job_tag_i, want);
        if (live_row.checked) want = live_row.view;
        views_due.push_back(want);
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (stall_left != 0) || (idling && !out_valid_o && $urandom_range(0, 3) == 0);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("** job_queue_remove_by_id: FAILED **");
    $finish;
  end

  initial begin
    job_row_t                   row;
    int unsigned                pick;
    bit                         filling;
    logic [jqr_pkg::FUNC_W-1:0] func;
    job_script = '{
      checked_row(jqr_pkg::FN_STATUS, 16'h0000, 16'h0000,
                  jqr_pkg::ST_DONE, NO_HEAD, 16'h0000, 1'b1, 5'd0),
      checked_row(jqr_pkg::FN_REMOVE, 16'h0000, 16'h0000,
                  jqr_pkg::ST_NOT_FOUND, NO_HEAD, 16'h0000, 1'b1, 5'd0),
      checked_row(FN_SPARE, 16'hFFFF, 16'hFFFF,
                  jqr_pkg::ST_DONE, NO_HEAD, 16'h0000, 1'b1, 5'd0),
      checked_row(jqr_pkg::FN_APPEND, 16'hFFFF, 16'h0000,
                  jqr_pkg::ST_DONE, 17'h0FFFF, 16'h0000, 1'b0, 5'd1),
      checked_row(jqr_pkg::FN_APPEND, 16'h0000, 16'hFFFF,
                  jqr_pkg::ST_DONE, 17'h0FFFF, 16'h0000, 1'b0, 5'd2),
      open_row(jqr_pkg::FN_APPEND, 16'h0005, 16'h1111),
      open_row(jqr_pkg::FN_APPEND, 16'h8001, 16'h2222),
      open_row(jqr_pkg::FN_APPEND, 16'h0005, 16'h3333),
      open_row(jqr_pkg::FN_APPEND, 16'h5555, 16'hAAAA),
      open_row(jqr_pkg::FN_APPEND, 16'hAAAA, 16'h5555),
      open_row(jqr_pkg::FN_APPEND, 16'h0001, 16'h0101),
      open_row(jqr_pkg::FN_APPEND, 16'h0002, 16'h0202),
      open_row(jqr_pkg::FN_APPEND, 16'h0004, 16'h0404),
      open_row(jqr_pkg::FN_APPEND, 16'h0008, 16'h0808),
      open_row(jqr_pkg::FN_APPEND, 16'h0010, 16'h1010),
      open_row(jqr_pkg::FN_APPEND, 16'h0020, 16'h2020),
      open_row(jqr_pkg::FN_APPEND, 16'h0040, 16'h4040),
      open_row(jqr_pkg::FN_APPEND, 16'h0080, 16'h8080),
      open_row(jqr_pkg::FN_APPEND, 16'h0100, 16'hC3C3),
      checked_row(jqr_pkg::FN_APPEND, 16'h1234, 16'h4321,
                  jqr_pkg::ST_FULL, 17'h0FFFF, 16'h0000, 1'b0, 5'd16),
      open_row(jqr_pkg::FN_REMOVE, 16'h0005, 16'h0000),
      open_row(jqr_pkg::FN_REMOVE, 16'hFFFF, 16'h0000),
      open_row(jqr_pkg::FN_REMOVE, 16'h1234, 16'h0000),
      open_row(jqr_pkg::FN_STATUS, 16'h0000, 16'h0000),
      open_row(FN_SPARE, 16'h5A5A, 16'hA5A5)
    };
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (job_script[r]) send_job(job_script[r]);
    for (int unsigned k = 0; k < RANDOM_JOBS; k++) begin
      idling = ((k / 128) % 3) != 2;
      filling = ((k / 48) % 2) == 0;
      pick = $urandom_range(0, 99);
      if (pick < (filling ? 65 : 25)) func = jqr_pkg::FN_APPEND;
      else if (pick < 85) func = jqr_pkg::FN_REMOVE;
      else if (pick < 95) func = jqr_pkg::FN_STATUS;
      else func = FN_SPARE;
      row = open_row(func, '0, jqr_pkg::TAG_W'($urandom_range(0, 16'hFFFF)));
      if (func == jqr_pkg::FN_REMOVE && held_jobs != 0 && $urandom_range(0, 3) != 0)
        row.id = jqr_pkg::ID_IN_W'(held_id[$urandom_range(0, held_jobs - 1)]);
      else if ($urandom_range(0, 1) != 0)
        row.id = jqr_pkg::ID_IN_W'($urandom_range(0, 7));
      else
        row.id = jqr_pkg::ID_IN_W'($urandom_range(0, 16'hFFFF));
      send_job(row);
    end
    in_valid_i <= 1'b0;
    while (views_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (faults == 0) begin
      $display("** job_queue_remove_by_id: PASSED **");
    end else begin
      $display("** job_queue_remove_by_id: FAILED **");
    end
    $finish;
  end

endmodule

FILE: job_queue_remove_by_id.f
src/jqr_pkg.sv
src/jqr_ram.sv
src/job_queue_remove_by_id.sv
src/jqr_checker.sv
sim/tb.sv
